// ===== hdl/bjt_pkg.sv =====
// ----------------------------------------------------------------------------
// bjt_pkg
// Types and constants for the eased Bezier jump trajectory generator.
// ----------------------------------------------------------------------------
package bjt_pkg;

  localparam int T_FRAC_BITS_DEF = 16;
  localparam int POS_W           = 24;
  localparam int TIME_W          = 24;
  localparam int ELAP_W          = 20;
  localparam int CRD_W           = 26;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_TRIG = 1'b1;

  localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_JUMP = 2'd1,
    PH_RET  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_WB,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_SQ,
    OP_VV,
    OP_VE,
    OP_EE,
    OP_X0,
    OP_X1,
    OP_X2,
    OP_Y0,
    OP_Y1,
    OP_Y2
  } op_t;

  typedef struct packed {
    logic                     req_type;
    logic [ELAP_W-1:0]        elapsed_us;
    logic signed [POS_W-1:0]  start_x;
    logic signed [POS_W-1:0]  start_y;
    logic signed [POS_W-1:0]  target_x;
    logic signed [POS_W-1:0]  target_y;
    logic signed [POS_W-1:0]  arc_lift;
    logic [TIME_W-1:0]        phase_time_us;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic                     phase_now;
    logic                     phase_end;
  } out_t;

endpackage

// ===== hdl/bezier_jump_trajectory.sv =====
// ----------------------------------------------------------------------------
// bezier_jump_trajectory
// Jump-and-return motion generator: timer, restoring divider for t, and one
// shared multiplier that forms the ease, the Bezier weights and the position.
// ----------------------------------------------------------------------------
// sequence: a trigger is taken directly in ST_IDLE; a tick in an active phase
// runs ST_PREP, ST_DIV (skipped when t saturates at 1), ten ST_MUL/ST_WB
// passes through the shared multiplier and ST_OUT; the divider gives one bit
// per cycle, and in_stall holds new requests off until the block is idle again
// reset: synchronous active-low rst_n clears the sequencer, phase and timer
module bezier_jump_trajectory #(
  parameter int T_FRAC_BITS = bjt_pkg::T_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bjt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output bjt_pkg::out_t out_data
);
  import bjt_pkg::*;

  localparam int TW     = T_FRAC_BITS + 1;
  localparam int AW     = T_FRAC_BITS + 2;
  localparam int PW     = AW + CRD_W;
  localparam int ACC_W  = PW + 1;
  localparam int STEP_W = $clog2(T_FRAC_BITS);
  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  state_t                  state_r, state_nxt;
  phase_t                  phase_r, phase_nxt;
  op_t                     op_r, op_nxt;
  logic [STEP_W-1:0]       cnt_r, cnt_nxt;
  logic [TIME_W-1:0]       acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_r, out_nxt;

  logic signed [POS_W-1:0] origin_x_r, origin_y_r, goal_x_r, goal_y_r, lift_r;
  logic [TIME_W-1:0]       span_r;
  logic [TIME_W-1:0]       rem_r, rem_nxt;
  logic [TW-1:0]           t_r, t_nxt;
  logic                    done_r, done_nxt;
  logic [TW-1:0]           e_r, e_nxt, w0_r, w0_nxt, w1_r, w1_nxt, w2_r, w2_nxt;
  logic signed [CRD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [ACC_W-1:0] sum_r, sum_nxt;
  logic signed [POS_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [PW-1:0]    prod_r;

  logic                    in_xfer, out_load, ret;
  logic [TIME_W:0]         tsum;
  logic [TIME_W:0]         r2, r2_diff;
  logic                    r2_ge;
  logic [TW-1:0]           sq_x, v;
  logic signed [POS_W-1:0] ax, ay, bx, by;
  logic signed [AW-1:0]    mul_a;
  logic signed [CRD_W-1:0] mul_b;
  logic signed [ACC_W-1:0] sum_add;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] sh;
    logic [ACC_W-POS_W:0]    top;
    sh  = s >>> T_FRAC_BITS;
    top = sh[ACC_W-1:POS_W-1];
    if (top == '0 || top == '1) begin
      sat_pos = sh[POS_W-1:0];
    end else if (sh[ACC_W-1]) begin
      sat_pos = POS_MIN;
    end else begin
      sat_pos = POS_MAX;
    end
  endfunction

  // handshake decode
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    in_xfer   = in_valid && (state_r == ST_IDLE);
    out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
    out_valid = out_valid_r;
    out_data  = out_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_data.req_type == REQ_TICK &&
            (phase_r == PH_JUMP || phase_r == PH_RET)) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: state_nxt = (acc_r >= span_r) ? ST_MUL : ST_DIV;
      ST_DIV: begin
        if (cnt_r == STEP_W'(T_FRAC_BITS - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_WB;
      ST_WB:  state_nxt = (op_r == OP_Y2) ? ST_OUT : ST_MUL;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign ret     = (phase_r == PH_RET);
  assign tsum    = {1'b0, acc_r} + (TIME_W + 1)'(in_data.elapsed_us);
  assign r2      = {rem_r, 1'b0};
  assign r2_diff = r2 - {1'b0, span_r};
  assign r2_ge   = (r2 >= {1'b0, span_r});
  assign sq_x    = ret ? (T_ONE - t_r) : t_r;
  assign v       = T_ONE - e_r;
  assign ax      = ret ? goal_x_r : origin_x_r;
  assign ay      = ret ? goal_y_r : origin_y_r;
  assign bx      = ret ? origin_x_r : goal_x_r;
  assign by      = ret ? origin_y_r : goal_y_r;
  assign sum_add = sum_r + ACC_W'(prod_r);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_SQ: begin mul_a = AW'(sq_x); mul_b = CRD_W'(sq_x); end
      OP_VV: begin mul_a = AW'(v);    mul_b = CRD_W'(v);    end
      OP_VE: begin mul_a = AW'(v);    mul_b = CRD_W'(e_r);  end
      OP_EE: begin mul_a = AW'(e_r);  mul_b = CRD_W'(e_r);  end
      OP_X0: begin mul_a = AW'(w0_r); mul_b = CRD_W'(ax);   end
      OP_X1: begin mul_a = AW'(w1_r); mul_b = cx_r;         end
      OP_X2: begin mul_a = AW'(w2_r); mul_b = CRD_W'(bx);   end
      OP_Y0: begin mul_a = AW'(w0_r); mul_b = CRD_W'(ay);   end
      OP_Y1: begin mul_a = AW'(w1_r); mul_b = cy_r;         end
      OP_Y2: begin mul_a = AW'(w2_r); mul_b = CRD_W'(by);   end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // datapath and phase updates
  always_comb begin
    phase_nxt     = phase_r;
    acc_nxt       = acc_r;
    op_nxt        = op_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    t_nxt         = t_r;
    done_nxt      = done_r;
    e_nxt         = e_r;
    w0_nxt        = w0_r;
    w1_nxt        = w1_r;
    w2_nxt        = w2_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    sum_nxt       = sum_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.req_type == REQ_TRIG) begin
            acc_nxt   = '0;
            phase_nxt = PH_JUMP;
          end else if (phase_r == PH_JUMP || phase_r == PH_RET) begin
            acc_nxt = tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
          end
        end
      end
      ST_PREP: begin
        cx_nxt   = (CRD_W'(ax) + CRD_W'(bx)) >>> 1;
        cy_nxt   = ((CRD_W'(ay) + CRD_W'(by)) >>> 1) + CRD_W'(lift_r);
        done_nxt = (acc_r >= span_r);
        t_nxt    = (acc_r >= span_r) ? T_ONE : '0;
        rem_nxt  = acc_r;
        cnt_nxt  = '0;
        op_nxt   = OP_SQ;
      end
      ST_DIV: begin
        rem_nxt = r2_ge ? r2_diff[TIME_W-1:0] : r2[TIME_W-1:0];
        t_nxt   = {t_r[TW-2:0], r2_ge};
        cnt_nxt = cnt_r + STEP_W'(1);
      end
      ST_WB: begin
        case (op_r)
          OP_SQ: e_nxt = ret ? (T_ONE - prod_r[T_FRAC_BITS +: TW])
                             : prod_r[T_FRAC_BITS +: TW];
          OP_VV: w0_nxt = prod_r[T_FRAC_BITS +: TW];
          OP_VE: w1_nxt = prod_r[T_FRAC_BITS-1 +: TW];
          OP_EE: w2_nxt = prod_r[T_FRAC_BITS +: TW];
          OP_X0, OP_Y0: sum_nxt = ACC_W'(prod_r);
          OP_X1, OP_Y1: sum_nxt = sum_add;
          OP_X2: px_nxt = sat_pos(sum_add);
          OP_Y2: py_nxt = sat_pos(sum_add);
          default: sum_nxt = sum_r;
        endcase
        op_nxt = op_t'(op_r + 4'd1);
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt     = 1'b1;
          out_nxt.pos_x     = (done_r && ret) ? origin_x_r : px_r;
          out_nxt.pos_y     = (done_r && ret) ? origin_y_r : py_r;
          out_nxt.phase_now = ret;
          out_nxt.phase_end = done_r;
          if (done_r) begin
            if (ret) begin
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_RET;
              acc_nxt   = '0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_data.req_type == REQ_TRIG) begin
      origin_x_r <= in_data.start_x;
      origin_y_r <= in_data.start_y;
      goal_x_r   <= in_data.target_x;
      goal_y_r   <= in_data.target_y;
      lift_r     <= in_data.arc_lift;
      span_r     <= in_data.phase_time_us;
    end
    if (state_r == ST_MUL) begin
      prod_r <= mul_a * mul_b;
    end
    op_r   <= op_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    t_r    <= t_nxt;
    done_r <= done_nxt;
    e_r    <= e_nxt;
    w0_r   <= w0_nxt;
    w1_r   <= w1_nxt;
    w2_r   <= w2_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    sum_r  <= sum_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    out_r  <= out_nxt;
  end

endmodule

// ===== bench/tb_bezier_jump_trajectory.sv =====
// ----------------------------------------------------------------------------
// tb_bezier_jump_trajectory
// Self-checking bench for the jump-and-return trajectory generator. A queue of
// trigger and tick requests feeds a valid/stall driver; each accepted request
// goes through an in-bench model of the timer, ease and Bezier math, and every
// result transfer is compared field by field against the oldest prediction.
// Both sides idle in random bursts, and the receiver holds off once for a long
// stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_bezier_jump_trajectory;
  import bjt_pkg::*;

  localparam int TF = T_FRAC_BITS_DEF;
  localparam longint unsigned T_UNIT = 64'd1 << TF;
  localparam int unsigned ELAP_TOP = 20'hFFFFF;
  localparam int unsigned SPAN_TOP = 24'hFFFFFF;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 600;
  localparam int IN_W = $bits(in_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  bezier_jump_trajectory dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // motion state mirrored from the block
  phase_t mode;
  logic [TIME_W-1:0] timer_us;
  logic [TIME_W-1:0] span_us;
  logic signed [POS_W-1:0] home_x, home_y, aim_x, aim_y, arc;

  in_t move_reqs[$];
  out_t want_pos[$];
  int planned_items = 0;
  int accepted_items = 0;
  int trig_count = 0;
  int tick_count = 0;
  int checked = 0;
  int jump_ends = 0;
  int return_ends = 0;
  int failures = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit held = 1'b0;
  int quiet_cycles = 0;

  wire calm = (planned_items - accepted_items) < 120;

  function automatic longint curve_point(longint a, longint c, longint b,
                                         longint unsigned ease);
    longint unsigned v;
    longint w0, w1, w2, p;
    v = T_UNIT - ease;
    w0 = longint'((v * v) >> TF);
    w1 = longint'((2 * v * ease) >> TF);
    w2 = longint'((ease * ease) >> TF);
    p = (w0 * a + w1 * c + w2 * b) >>> TF;
    if (p > 64'sd8388607) p = 64'sd8388607;
    if (p < -64'sd8388608) p = -64'sd8388608;
    return p;
  endfunction

  function automatic bit step_trajectory(input in_t req, output out_t res);
    longint unsigned sum, tq, ease, u;
    longint ax, ay, bx, by, cx, cy, px, py;
    bit done, back;
    res = '0;
    if (req.req_type == REQ_TRIG) begin
      home_x = req.start_x;
      home_y = req.start_y;
      aim_x = req.target_x;
      aim_y = req.target_y;
      arc = req.arc_lift;
      span_us = req.phase_time_us;
      timer_us = '0;
      mode = PH_JUMP;
      return 1'b0;
    end
    if (mode != PH_JUMP && mode != PH_RET) return 1'b0;
    sum = longint'(timer_us) + longint'(req.elapsed_us);
    timer_us = (sum > SPAN_TOP) ? TIME_W'(SPAN_TOP) : sum[TIME_W-1:0];
    if (span_us == 0) begin
      tq = T_UNIT;
    end else begin
      tq = (longint'(timer_us) << TF) / longint'(span_us);
      if (tq > T_UNIT) tq = T_UNIT;
    end
    done = (tq >= T_UNIT);
    back = (mode == PH_RET);
    if (!back) begin
      ease = (tq * tq) >> TF;
      ax = home_x; ay = home_y; bx = aim_x; by = aim_y;
    end else begin
      u = T_UNIT - tq;
      ease = T_UNIT - ((u * u) >> TF);
      ax = aim_x; ay = aim_y; bx = home_x; by = home_y;
    end
    cx = (ax + bx) >>> 1;
    cy = ((ay + by) >>> 1) + longint'(arc);
    px = curve_point(ax, cx, bx, ease);
    py = curve_point(ay, cy, by, ease);
    if (done) begin
      if (!back) begin
        mode = PH_RET;
        timer_us = '0;
      end else begin
        mode = PH_IDLE;
        px = home_x;
        py = home_y;
      end
    end
    res.pos_x = px[POS_W-1:0];
    res.pos_y = py[POS_W-1:0];
    res.phase_now = back;
    res.phase_end = done;
    return 1'b1;
  endfunction

  function automatic logic signed [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 5))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return POS_W'(int'($urandom_range(0, 4000)) - 2000);
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic void queue_trigger(logic signed [POS_W-1:0] sx, logic signed [POS_W-1:0] sy,
                                        logic signed [POS_W-1:0] tx, logic signed [POS_W-1:0] ty,
                                        logic signed [POS_W-1:0] lf, int unsigned span);
    in_t req;
    req.req_type = REQ_TRIG;
    req.elapsed_us = ELAP_W'($urandom);
    req.start_x = sx;
    req.start_y = sy;
    req.target_x = tx;
    req.target_y = ty;
    req.arc_lift = lf;
    req.phase_time_us = span[TIME_W-1:0];
    move_reqs.push_back(req);
  endfunction

  function automatic void queue_tick(int unsigned el);
    in_t req;
    req = in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    req.req_type = REQ_TICK;
    req.elapsed_us = el[ELAP_W-1:0];
    move_reqs.push_back(req);
  endfunction

  task automatic check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      mode = PH_IDLE;
      timer_us = '0;
      span_us = '0;
      home_x = '0; home_y = '0; aim_x = '0; aim_y = '0; arc = '0;
    end else begin
      if (in_valid && !in_stall) begin
        out_t res;
        if (in_data.req_type == REQ_TRIG) trig_count++;
        else tick_count++;
        if (step_trajectory(in_data, res)) want_pos.push_back(res);
        accepted_items++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (move_reqs.size() != 0) begin
          in_data <= move_reqs.pop_front();
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_pos.size() == 0) begin
          failures++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          out_t want;
          want = want_pos.pop_front();
          check_field("pos_x", want.pos_x, out_data.pos_x);
          check_field("pos_y", want.pos_y, out_data.pos_y);
          check_field("phase_now", POS_W'(want.phase_now), POS_W'(out_data.phase_now));
          check_field("phase_end", POS_W'(want.phase_end), POS_W'(out_data.phase_end));
          if (want.phase_end && !want.phase_now) jump_ends++;
          if (want.phase_end && want.phase_now) return_ends++;
        end
        checked++;
      end
      if (!held && checked >= 120) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout after %0d idle cycles", $time, quiet_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned span, steps, stride, need, el;
    int kind;
    // directed
    queue_tick(5);
    queue_trigger(POS_MAX, POS_MIN, POS_MIN, POS_MAX, POS_MAX, 0);
    queue_tick(0);
    queue_tick(0);
    queue_tick(ELAP_TOP);
    queue_trigger(POS_MIN, POS_MAX, POS_MAX, POS_MIN, POS_MIN, 1000);
    queue_tick(0);
    queue_tick(250);
    queue_tick(500);
    queue_tick(250);
    queue_tick(1);
    queue_tick(300);
    queue_trigger(POS_W'(-1280), POS_W'(512), POS_W'(25600), POS_W'(-6400),
                  POS_W'(12800), 4000);
    queue_tick(1000);
    queue_trigger('0, '0, '0, '0, '0, 1);
    queue_tick(1);
    queue_tick(ELAP_TOP);
    queue_trigger(POS_W'(100), POS_W'(200), POS_W'(300), POS_W'(400), POS_W'(-500),
                  SPAN_TOP);
    queue_tick(ELAP_TOP);
    queue_tick(ELAP_TOP);
    queue_trigger(POS_W'(1), POS_W'(-1), POS_W'(-1), POS_W'(1), '0, 3);
    queue_tick(1);
    queue_tick(1);
    queue_tick(1);
    queue_tick(2);
    // random
    while (move_reqs.size() < 775) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        case ($urandom_range(0, 9))
          0: span = 0;
          1, 2, 3, 4: span = $urandom_range(1, 5000);
          5, 6, 7, 8: span = $urandom_range(5000, 1000000);
          default: span = $urandom_range(1000000, SPAN_TOP);
        endcase
        queue_trigger(pick_pos(), pick_pos(), pick_pos(), pick_pos(), pick_pos(), span);
        steps = $urandom_range(1, 6);
        stride = span / steps;
        if (stride > ELAP_TOP) stride = ELAP_TOP;
        need = (stride == 0) ? 1 : (span + stride - 1) / stride;
        repeat (2 * need + 1) begin
          if (stride == 0) el = $urandom_range(0, 3);
          else el = stride - stride / 8 + $urandom_range(0, stride / 4);
          if ($urandom_range(0, 15) == 0) el = 0;
          queue_tick((el > ELAP_TOP) ? ELAP_TOP : el);
        end
      end else if (kind < 85) begin
        queue_trigger(pick_pos(), pick_pos(), pick_pos(), pick_pos(), pick_pos(),
                      $urandom_range(0, 200000));
        repeat ($urandom_range(0, 3)) queue_tick($urandom_range(0, 100000));
      end else if (kind < 98) begin
        queue_tick($urandom_range(0, 1) ? $urandom_range(0, ELAP_TOP) : $urandom_range(0, 64));
      end else begin
        // timer saturation on a long phase
        queue_trigger(pick_pos(), pick_pos(), pick_pos(), pick_pos(), pick_pos(),
                      SPAN_TOP - $urandom_range(0, 3));
        repeat (35) queue_tick(ELAP_TOP);
      end
    end
    planned_items = move_reqs.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_items < planned_items) @(posedge clk);
    while (want_pos.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("covered %0d transfers in (%0d triggers, %0d ticks), %0d results checked",
             accepted_items, trig_count, tick_count, checked);
    $display("phase ends seen: %0d jump, %0d return; %0d mismatches",
             jump_ends, return_ends, failures);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
